/* design/assert_macros.svh */
// assertion helpers, clocked with synchronous active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/tun_pkg.sv */
package tun_pkg;
    localparam int COORD_WIDTH_DEF      = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int NORM_W = 16;   // output component width
    localparam int MAG_W  = 31;   // normalized magnitude, top bit at 2^30
    localparam int SQ_W   = 64;   // sum of squares
    localparam int ROOT_W = 32;   // integer square root
endpackage

/* design/tun_if.sv */
interface tun_tri_if #(parameter int CW = 16);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] ax, ay, az;
    logic signed [CW-1:0] bx, by, bz;
    logic signed [CW-1:0] cx, cy, cz;

    modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
    modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

interface tun_nrm_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] nx, ny, nz;
    logic               degenerate;

    modport source (output valid, nx, ny, nz, degenerate, input ready);
    modport sink   (input valid, nx, ny, nz, degenerate, output ready);
endinterface

/* design/tun_sqrt.sv */
module tun_sqrt
    import tun_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [SQ_W-1:0]   i_sum,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0] o_side
);
    // two result bits per stage
    localparam int NSTG = ROOT_W / 2;

    logic              r_vld  [NSTG];
    logic [SQ_W-1:0]   r_rad  [NSTG];
    logic [ROOT_W+1:0] r_rem  [NSTG];
    logic [ROOT_W-1:0] r_root [NSTG];
    logic [SIDE_W-1:0] r_side [NSTG];

    logic [SQ_W-1:0]   n_rad  [NSTG];
    logic [ROOT_W+1:0] n_rem  [NSTG];
    logic [ROOT_W-1:0] n_root [NSTG];

    for (genvar g = 0; g < NSTG; g++) begin : g_stg
        logic              p_vld;
        logic [SQ_W-1:0]   p_rad;
        logic [ROOT_W+1:0] p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [SIDE_W-1:0] p_side;

        if (g == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_rad  = i_sum;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[g-1];
            assign p_rad  = r_rad[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_root = r_root[g-1];
            assign p_side = r_side[g-1];
        end

        always_comb begin
            logic [ROOT_W+1:0] rem;
            logic [ROOT_W+1:0] trial;
            logic [ROOT_W-1:0] root;
            logic [SQ_W-1:0]   rad;
            rem  = p_rem;
            root = p_root;
            rad  = p_rad;
            for (int k = 0; k < 2; k++) begin
                rem   = {rem[ROOT_W-1:0], rad[SQ_W-1 -: 2]};
                trial = {root, 2'b01};
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = {root[ROOT_W-2:0], 1'b1};
                end else begin
                    root = {root[ROOT_W-2:0], 1'b0};
                end
                rad = rad << 2;
            end
            n_rem[g]  = rem;
            n_root[g] = root;
            n_rad[g]  = rad;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[g]  <= n_rad[g];
                r_rem[g]  <= n_rem[g];
                r_root[g] <= n_root[g];
                r_side[g] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[NSTG-1];
    assign o_root = r_root[NSTG-1];
    assign o_side = r_side[NSTG-1];
endmodule

/* design/tun_div.sv */
module tun_div
    import tun_pkg::*;
#(
    parameter int FRAC   = NORMAL_FRAC_BITS_DEF,
    parameter int SIDE_W = 1,
    localparam int QW    = FRAC + 1,
    localparam int NSTG  = (QW + 1) / 2,
    localparam int DST   = 2 * NSTG
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [2:0][MAG_W-1:0]      i_mag,
    input  logic [ROOT_W-1:0]          i_len,
    input  logic [SIDE_W-1:0]          i_side,
    output logic                       o_vld,
    output logic [2:0][DST-1:0]        o_quo,
    output logic [SIDE_W-1:0]          o_side
);
    // rounded quotient (m * 2^FRAC + len/2) / len, two bits per stage
    localparam int NUMW = MAG_W + FRAC + 1;

    logic [2:0][DST-1:0]    s_low;
    logic [2:0][ROOT_W-1:0] s_rem;

    always_comb begin
        logic [NUMW-1:0] num;
        for (int c = 0; c < 3; c++) begin
            num = {1'b0, i_mag[c], {FRAC{1'b0}}} + NUMW'(i_len >> 1);
            s_rem[c] = ROOT_W'(num >> DST);
            s_low[c] = num[DST-1:0];
        end
    end

    logic                   r_vld  [NSTG];
    logic [2:0][ROOT_W-1:0] r_rem  [NSTG];
    logic [2:0][DST-1:0]    r_low  [NSTG];
    logic [2:0][DST-1:0]    r_quo  [NSTG];
    logic [ROOT_W-1:0]      r_len  [NSTG];
    logic [SIDE_W-1:0]      r_side [NSTG];

    logic [2:0][ROOT_W-1:0] n_rem  [NSTG];
    logic [2:0][DST-1:0]    n_low  [NSTG];
    logic [2:0][DST-1:0]    n_quo  [NSTG];

    for (genvar g = 0; g < NSTG; g++) begin : g_stg
        logic                   p_vld;
        logic [2:0][ROOT_W-1:0] p_rem;
        logic [2:0][DST-1:0]    p_low;
        logic [2:0][DST-1:0]    p_quo;
        logic [ROOT_W-1:0]      p_len;
        logic [SIDE_W-1:0]      p_side;

        if (g == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_rem  = s_rem;
            assign p_low  = s_low;
            assign p_quo  = '0;
            assign p_len  = i_len;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_low  = r_low[g-1];
            assign p_quo  = r_quo[g-1];
            assign p_len  = r_len[g-1];
            assign p_side = r_side[g-1];
        end

        always_comb begin
            logic [ROOT_W:0]   t;
            logic [ROOT_W-1:0] rem;
            logic [DST-1:0]    low;
            logic [DST-1:0]    quo;
            for (int c = 0; c < 3; c++) begin
                rem = p_rem[c];
                low = p_low[c];
                quo = p_quo[c];
                for (int k = 0; k < 2; k++) begin
                    t = {rem, low[DST-1]};
                    if (t >= {1'b0, p_len}) begin
                        rem = ROOT_W'(t - {1'b0, p_len});
                        quo = {quo[DST-2:0], 1'b1};
                    end else begin
                        rem = t[ROOT_W-1:0];
                        quo = {quo[DST-2:0], 1'b0};
                    end
                    low = low << 1;
                end
                n_rem[g][c] = rem;
                n_low[g][c] = low;
                n_quo[g][c] = quo;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem[g];
                r_low[g]  <= n_low[g];
                r_quo[g]  <= n_quo[g];
                r_len[g]  <= p_len;
                r_side[g] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[NSTG-1];
    assign o_quo  = r_quo[NSTG-1];
    assign o_side = r_side[NSTG-1];
endmodule

/* design/triangle_unit_normal.sv */
// Pipeline: edges, products, sign and magnitude, normalize shifts, squares, sum of squares,
//   square root, divider and output register, from accepted triangle to result.
// Throughput: one triangle per cycle; fully pipelined square root and divider.
// A stalled output holds the whole pipeline.
// Reset: synchronous, active low; clears all valid bits, the data path is not reset.
`include "assert_macros.svh"

module triangle_unit_normal
    import tun_pkg::*;
#(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tun_tri_if.sink    i_tri,
    tun_nrm_if.source  o_nrm
);
    localparam int EW   = COORD_WIDTH + 1;
    localparam int PW   = 2 * EW;
    localparam int DW   = PW + 1;
    localparam int MW   = 2 * COORD_WIDTH + 2;
    localparam int NW   = (MW > MAG_W) ? MW : MAG_W;
    localparam int NST  = $clog2(NW);
    localparam int QW   = NORMAL_FRAC_BITS + 1;
    localparam int DST  = 2 * ((QW + 1) / 2);
    localparam int SQW  = 2 * MAG_W;
    localparam int SSW  = 3 * MAG_W + 4;

    logic en;
    logic r_out_vld;

    assign en          = !r_out_vld || o_nrm.ready;
    assign i_tri.ready = en;

    // edges
    logic                 r_a_vld;
    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e1[0] <= EW'(i_tri.bx) - EW'(i_tri.ax);
            r_e1[1] <= EW'(i_tri.by) - EW'(i_tri.ay);
            r_e1[2] <= EW'(i_tri.bz) - EW'(i_tri.az);
            r_e2[0] <= EW'(i_tri.cx) - EW'(i_tri.ax);
            r_e2[1] <= EW'(i_tri.cy) - EW'(i_tri.ay);
            r_e2[2] <= EW'(i_tri.cz) - EW'(i_tri.az);
        end
    end

    // products of E2 x E1
    logic                 r_b_vld;
    logic signed [PW-1:0] r_p [6];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0] <= PW'(r_e2[1]) * PW'(r_e1[2]);
            r_p[1] <= PW'(r_e2[2]) * PW'(r_e1[1]);
            r_p[2] <= PW'(r_e2[2]) * PW'(r_e1[0]);
            r_p[3] <= PW'(r_e2[0]) * PW'(r_e1[2]);
            r_p[4] <= PW'(r_e2[0]) * PW'(r_e1[1]);
            r_p[5] <= PW'(r_e2[1]) * PW'(r_e1[0]);
        end
    end

    // sign and magnitude
    logic                 r_c_vld;
    logic [2:0][NW-1:0]   r_c_mag;
    logic [2:0]           r_c_neg;
    logic                 r_c_dg;
    logic signed [DW-1:0] n_d [3];
    logic [2:0][NW-1:0]   n_c_mag;
    logic [2:0]           n_c_neg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_d[c]     = DW'(r_p[2*c]) - DW'(r_p[2*c+1]);
            n_c_neg[c] = n_d[c][DW-1];
            n_c_mag[c] = NW'(MW'(n_c_neg[c] ? -n_d[c] : n_d[c]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_mag <= n_c_mag;
            r_c_neg <= n_c_neg;
            r_c_dg  <= (n_d[0] == '0) && (n_d[1] == '0) && (n_d[2] == '0);
        end
    end

    // left-justify the largest magnitude, one power-of-two shift per stage
    logic               r_n_vld [NST];
    logic [2:0][NW-1:0] r_n_mag [NST];
    logic [2:0]         r_n_neg [NST];
    logic               r_n_dg  [NST];
    logic [2:0][NW-1:0] n_n_mag [NST];

    for (genvar g = 0; g < NST; g++) begin : g_nrm
        localparam int SH = 1 << (NST - 1 - g);
        logic               p_vld;
        logic [2:0][NW-1:0] p_mag;
        logic [2:0]         p_neg;
        logic               p_dg;
        logic [NW-1:0]      p_or;

        if (g == 0) begin : g_first
            assign p_vld = r_c_vld;
            assign p_mag = r_c_mag;
            assign p_neg = r_c_neg;
            assign p_dg  = r_c_dg;
        end else begin : g_next
            assign p_vld = r_n_vld[g-1];
            assign p_mag = r_n_mag[g-1];
            assign p_neg = r_n_neg[g-1];
            assign p_dg  = r_n_dg[g-1];
        end

        assign p_or = p_mag[0] | p_mag[1] | p_mag[2];

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                n_n_mag[g][c] = (p_or[NW-1 -: SH] == '0) ? (p_mag[c] << SH) : p_mag[c];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_n_vld[g] <= 1'b0;
            end else if (en) begin
                r_n_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_n_mag[g] <= n_n_mag[g];
                r_n_neg[g] <= p_neg;
                r_n_dg[g]  <= p_dg;
            end
        end
    end

    // squares
    logic                  r_q_vld;
    logic [2:0][MAG_W-1:0] r_q_m;
    logic [2:0][SQW-1:0]   r_q_sq;
    logic [2:0]            r_q_neg;
    logic                  r_q_dg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r_q_m[c]  <= r_n_mag[NST-1][c][NW-1 -: MAG_W];
                r_q_sq[c] <= SQW'(r_n_mag[NST-1][c][NW-1 -: MAG_W])
                           * SQW'(r_n_mag[NST-1][c][NW-1 -: MAG_W]);
            end
            r_q_neg <= r_n_neg[NST-1];
            r_q_dg  <= r_n_dg[NST-1];
        end
    end

    // sum of squares
    logic                  r_s_vld;
    logic [SQ_W-1:0]       r_s_sum;
    logic [2:0][MAG_W-1:0] r_s_m;
    logic [2:0]            r_s_neg;
    logic                  r_s_dg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_sum <= SQ_W'(r_q_sq[0]) + SQ_W'(r_q_sq[1]) + SQ_W'(r_q_sq[2]);
            r_s_m   <= r_q_m;
            r_s_neg <= r_q_neg;
            r_s_dg  <= r_q_dg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_q_vld <= 1'b0;
            r_s_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_tri.valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_q_vld <= r_n_vld[NST-1];
            r_s_vld <= r_q_vld;
        end
    end

    // length
    logic                  sq_vld;
    logic [ROOT_W-1:0]     sq_root;
    logic [SSW-1:0]        sq_side;
    logic [2:0][MAG_W-1:0] sq_m;
    logic [2:0]            sq_neg;
    logic                  sq_dg;

    tun_sqrt #(
        .SIDE_W (SSW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_s_vld),
        .i_sum   (r_s_sum),
        .i_side  ({r_s_m, r_s_neg, r_s_dg}),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    assign {sq_m, sq_neg, sq_dg} = sq_side;

    // per-component division
    logic                dv_vld;
    logic [2:0][DST-1:0] dv_quo;
    logic [2:0]          dv_neg;
    logic                dv_dg;

    tun_div #(
        .FRAC   (NORMAL_FRAC_BITS),
        .SIDE_W (4)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq_vld),
        .i_mag   (sq_m),
        .i_len   (sq_root),
        .i_side  ({sq_neg, sq_dg}),
        .o_vld   (dv_vld),
        .o_quo   (dv_quo),
        .o_side  ({dv_neg, dv_dg})
    );

    // output word
    logic [NORM_W-1:0] n_out [3];

    always_comb begin
        logic [NORM_W-1:0] q;
        for (int c = 0; c < 3; c++) begin
            q = NORM_W'(dv_quo[c]);
            if (dv_dg) begin
                n_out[c] = '0;
            end else begin
                n_out[c] = dv_neg[c] ? q : -q;
            end
        end
    end

    logic signed [NORM_W-1:0] r_nx, r_ny, r_nz;
    logic                     r_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx <= n_out[0];
            r_ny <= n_out[1];
            r_nz <= n_out[2];
            r_dg <= dv_dg;
        end
    end

    assign o_nrm.valid      = r_out_vld;
    assign o_nrm.nx         = r_nx;
    assign o_nrm.ny         = r_ny;
    assign o_nrm.nz         = r_nz;
    assign o_nrm.degenerate = r_dg;

    `ASSERT_IMPL(a_dg_zero, i_clk, i_rst_n, o_nrm.valid && o_nrm.degenerate,
        o_nrm.nx == '0 && o_nrm.ny == '0 && o_nrm.nz == '0, "degenerate word has nonzero normal")
    `ASSERT_IMPL(a_len_range, i_clk, i_rst_n, sq_vld && !sq_dg,
        sq_root[ROOT_W-1 -: 2] != 2'b00, "length below normalized range")
    `ASSERT_NEXT(a_stall_in, i_clk, i_rst_n, o_nrm.valid && !o_nrm.ready,
        o_nrm.valid && !i_tri.ready || o_nrm.ready, "input taken during output stall")
endmodule

/* dv/tb_triangle_unit_normal.sv */
module tb_triangle_unit_normal;
    import tun_pkg::*;

    localparam int CW    = COORD_WIDTH_DEF;
    localparam int FRAC  = NORMAL_FRAC_BITS_DEF;
    localparam int LAT   = 40;
    localparam int LIMIT = 20000;

    typedef struct {
        logic signed [CW-1:0] c[9];
    } tri_t;

    typedef struct {
        logic signed [NORM_W-1:0] nx, ny, nz;
        logic                     degenerate;
    } nrm_t;

    logic i_clk;
    logic i_rst_n;

    tun_tri_if #(.CW(CW)) tri_ch ();
    tun_nrm_if            nrm_ch ();

    triangle_unit_normal #(.COORD_WIDTH(CW), .NORMAL_FRAC_BITS(FRAC)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tri   (tri_ch.sink),
        .o_nrm   (nrm_ch.source)
    );

    nrm_t expected_normals[$];
    int   n_errors;
    int   n_words_in;
    int   n_words_out;
    int   n_degenerate;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   idle_count;
    bit   timed_out;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic nrm_t face_normal(tri_t t);
        nrm_t r;
        logic signed [65:0] e1[3], e2[3], n[3];
        logic        [65:0] m[3];
        logic        [63:0] s[3], sum, len, q;
        logic        [63:0] rem;
        logic        [63:0] root, bitv;
        int maxlen, sh, l;
        for (int i = 0; i < 3; i++) begin
            e1[i] = 66'(t.c[3+i]) - 66'(t.c[i]);
            e2[i] = 66'(t.c[6+i]) - 66'(t.c[i]);
        end
        n[0] = e2[1] * e1[2] - e2[2] * e1[1];
        n[1] = e2[2] * e1[0] - e2[0] * e1[2];
        n[2] = e2[0] * e1[1] - e2[1] * e1[0];
        maxlen = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = n[i][65] ? -n[i] : n[i];
            l = 0;
            for (int b = 0; b < 66; b++) if (m[i][b]) l = b + 1;
            if (l > maxlen) maxlen = l;
        end
        r.nx = '0; r.ny = '0; r.nz = '0; r.degenerate = 1'b1;
        if (maxlen == 0) return r;
        sh = maxlen - 31;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            s[i] = (sh >= 0) ? 64'(m[i] >> sh) : 64'(m[i] << (-sh));
            sum += s[i] * s[i];
        end
        rem = sum;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        len = root;
        r.degenerate = 1'b0;
        for (int i = 0; i < 3; i++) begin
            q = ((s[i] << FRAC) + (len >> 1)) / len;
            if (!n[i][65] && n[i] != 0) q = -q;
            case (i)
                0: r.nx = q[NORM_W-1:0];
                1: r.ny = q[NORM_W-1:0];
                default: r.nz = q[NORM_W-1:0];
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        n_errors++;
        $display("ERROR word %0d: %s got %h expected %h", n_words_out, what, got, want);
    endtask

    task automatic send_triangle(tri_t t);
        nrm_t e;
        while ($urandom_range(99) < send_idle_pct) begin
            tri_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        tri_ch.valid <= 1'b1;
        tri_ch.ax <= t.c[0]; tri_ch.ay <= t.c[1]; tri_ch.az <= t.c[2];
        tri_ch.bx <= t.c[3]; tri_ch.by <= t.c[4]; tri_ch.bz <= t.c[5];
        tri_ch.cx <= t.c[6]; tri_ch.cy <= t.c[7]; tri_ch.cz <= t.c[8];
        do @(posedge i_clk); while (!tri_ch.ready);
        e = face_normal(t);
        if (e.degenerate) n_degenerate++;
        expected_normals.push_back(e);
        n_words_in++;
    endtask

    function automatic tri_t rand_tri(int mode);
        tri_t t;
        for (int i = 0; i < 9; i++) begin
            case (mode)
                0: t.c[i] = CW'($urandom);
                1: t.c[i] = CW'($signed($urandom_range(64)) - 32);
                default: t.c[i] = $urandom_range(1) ? 16'sh7fff - CW'($urandom_range(3))
                                                    : 16'sh8000 + CW'($urandom_range(3));
            endcase
        end
        return t;
    endfunction

    task automatic drain();
        tri_ch.valid <= 1'b0;
        while (expected_normals.size() != 0 && !timed_out) @(posedge i_clk);
    endtask

    task automatic test_directed();
        tri_t t;
        logic signed [CW-1:0] ext[4] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff};
        for (int i = 0; i < 9; i++) t.c[i] = '0;
        send_triangle(t);
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 9; i++) t.c[i] = ext[(i + k) % 4];
            send_triangle(t);
            for (int i = 0; i < 9; i++) t.c[i] = (i < 3) ? ext[k] : ext[(k + i / 3) % 4];
            send_triangle(t);
        end
        // unit axis triangle, collinear, coincident, max span
        t.c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
        send_triangle(t);
        t.c = '{1, 2, 3, 2, 4, 6, 3, 6, 9};
        send_triangle(t);
        t.c = '{5, 5, 5, 5, 5, 5, -7, 9, 1};
        send_triangle(t);
        t.c = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
                16'sh8000, 16'sh7fff, 16'sh8000};
        send_triangle(t);
        t.c = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
                16'sh8000, 16'sh7fff, 16'sh8000};
        send_triangle(t);
        t.c = '{0, 0, 0, 0, 0, 1, 0, 1, 0};
        send_triangle(t);
        t.c = '{0, 0, 0, 0, 1, 0, 1, 0, 0};
        send_triangle(t);
    endtask

    task automatic test_random(int count);
        tri_t t;
        int mode;
        for (int k = 0; k < count; k++) begin
            mode = $urandom_range(9);
            t = rand_tri(mode < 6 ? 0 : (mode < 9 ? 1 : 2));
            if ($urandom_range(19) == 0) begin
                for (int i = 3; i < 9; i++) t.c[i] = t.c[i % 3];
            end
            send_triangle(t);
        end
    endtask

    task automatic test_pause_until_drained();
        drain();
        test_random(10);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            nrm_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            if ((tri_ch.valid && tri_ch.ready) || (nrm_ch.valid && nrm_ch.ready)) begin
                idle_count <= 0;
            end else begin
                idle_count <= idle_count + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        nrm_t e;
        if (i_rst_n && nrm_ch.valid && nrm_ch.ready) begin
            if (expected_normals.size() == 0) begin
                n_errors++;
                $display("ERROR: normal word with nothing expected");
            end else begin
                e = expected_normals.pop_front();
                if (nrm_ch.nx !== e.nx) report_mismatch("nx", nrm_ch.nx, e.nx);
                if (nrm_ch.ny !== e.ny) report_mismatch("ny", nrm_ch.ny, e.ny);
                if (nrm_ch.nz !== e.nz) report_mismatch("nz", nrm_ch.nz, e.nz);
                if (nrm_ch.degenerate !== e.degenerate)
                    report_mismatch("degenerate", 16'(nrm_ch.degenerate), 16'(e.degenerate));
            end
            n_words_out++;
        end
    end

    initial begin
        wait (idle_count >= LIMIT);
        timed_out = 1'b1;
        $display("TIMEOUT: no words moved for %0d cycles", LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        tri_ch.valid = 1'b0;
        tri_ch.ax = '0; tri_ch.ay = '0; tri_ch.az = '0;
        tri_ch.bx = '0; tri_ch.by = '0; tri_ch.bz = '0;
        tri_ch.cx = '0; tri_ch.cy = '0; tri_ch.cz = '0;
        nrm_ch.ready = 1'b0;
        n_errors = 0; n_words_in = 0; n_words_out = 0; n_degenerate = 0;
        idle_count = 0; timed_out = 1'b0;
        send_idle_pct = 20;
        recv_idle_pct = 83;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(170);
        test_pause_until_drained();
        send_idle_pct = 83;
        recv_idle_pct = 20;
        test_random(180);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(170);
        drain();
        repeat (LAT) @(posedge i_clk);
        $display("Sent %0d triangles, checked %0d normals (%0d degenerate)",
                 n_words_in, n_words_out, n_degenerate);
        $display("Covered extreme corners, collinear and coincident faces, three idle mixes");
        if (n_errors == 0 && expected_normals.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+design
design/tun_pkg.sv
design/tun_if.sv
design/tun_sqrt.sv
design/tun_div.sv
design/triangle_unit_normal.sv
dv/tb_triangle_unit_normal.sv
